/* rtl/tbas_pkg.sv */
// Shared types, constants and register indexes for the twiddled blit address swizzle unit.
package tbas_pkg;

  localparam int COORD_BITS    = 12;
  localparam int MAX_LOG2_SIZE = 12;
  localparam int LOG2_BITS     = 4;
  localparam int START_BITS    = COORD_BITS + 1;
  localparam int PITCH_BITS    = 14;
  localparam int OFFSET_BITS   = 25;
  localparam int PIXEL_BITS    = 32;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 14;

  localparam logic [CFG_IDX_BITS-1:0] REG_SRC_X       = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_SRC_Y       = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_FLIP_MODE   = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_TWIDDLED    = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_LOG2_WIDTH  = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_LOG2_HEIGHT = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_ROW_PITCH   = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] REG_SWAP_RB     = 3'd7;

  typedef struct packed {
    logic [START_BITS-1:0] src_x;
    logic [START_BITS-1:0] src_y;
    logic [1:0]            flip_mode;
    logic                  twiddled;
    logic [LOG2_BITS-1:0]  log2_width;
    logic [LOG2_BITS-1:0]  log2_height;
    logic [PITCH_BITS-1:0] row_pitch_words;
    logic                  swap_rb;
  } cfg_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] dst_col;
    logic [COORD_BITS-1:0] dst_row;
    logic [PIXEL_BITS-1:0] pixel_in;
  } request_t;

  typedef struct packed {
    logic [OFFSET_BITS-1:0] src_word_offset;
    logic [PIXEL_BITS-1:0]  pixel_out;
    logic                   coord_error;
  } result_t;

endpackage

/* rtl/tbas_cfg_regs.sv */
// Configuration register file of the twiddled blit address swizzle unit.
module tbas_cfg_regs (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [tbas_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [tbas_pkg::CFG_DATA_BITS-1:0] cfg_data,
  output tbas_pkg::cfg_t                    cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.src_x           <= '0;
      cfg.src_y           <= '0;
      cfg.flip_mode       <= '0;
      cfg.twiddled        <= 1'b0;
      cfg.log2_width      <= '0;
      cfg.log2_height     <= '0;
      cfg.row_pitch_words <= tbas_pkg::PITCH_BITS'(1);
      cfg.swap_rb         <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        tbas_pkg::REG_SRC_X:       cfg.src_x <= cfg_data[tbas_pkg::START_BITS-1:0];
        tbas_pkg::REG_SRC_Y:       cfg.src_y <= cfg_data[tbas_pkg::START_BITS-1:0];
        tbas_pkg::REG_FLIP_MODE:   cfg.flip_mode <= cfg_data[1:0];
        tbas_pkg::REG_TWIDDLED:    cfg.twiddled <= cfg_data[0];
        tbas_pkg::REG_LOG2_WIDTH:  cfg.log2_width <= cfg_data[tbas_pkg::LOG2_BITS-1:0];
        tbas_pkg::REG_LOG2_HEIGHT: cfg.log2_height <= cfg_data[tbas_pkg::LOG2_BITS-1:0];
        tbas_pkg::REG_ROW_PITCH:   cfg.row_pitch_words <= cfg_data[tbas_pkg::PITCH_BITS-1:0];
        tbas_pkg::REG_SWAP_RB:     cfg.swap_rb <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

/* rtl/tbas_src_coord.sv */
// Source coordinate from box start and box index, with range check.
module tbas_src_coord (
  input  logic [tbas_pkg::START_BITS-1:0] start,
  input  logic [tbas_pkg::COORD_BITS-1:0] idx,
  input  logic                            mirror,
  output logic [tbas_pkg::COORD_BITS-1:0] coord,
  output logic                            bad
);

  localparam int SUM_BITS = tbas_pkg::COORD_BITS + 3;

  logic [SUM_BITS-1:0] sum;

  // Two guard bits above the start width catch both negative and too-large values.
  always_comb begin
    if (mirror) begin
      sum = SUM_BITS'(start) - SUM_BITS'(1) - SUM_BITS'(idx);
    end else begin
      sum = SUM_BITS'(start) + SUM_BITS'(idx);
    end
    bad   = |sum[SUM_BITS-1:tbas_pkg::COORD_BITS];
    coord = sum[tbas_pkg::COORD_BITS-1:0];
  end

endmodule

/* rtl/tbas_offset.sv */
// Twiddled (Morton) or linear source word offset from source column and row.
module tbas_offset (
  input  tbas_pkg::cfg_t                   cfg,
  input  logic [tbas_pkg::COORD_BITS-1:0]  ux,
  input  logic [tbas_pkg::COORD_BITS-1:0]  uy,
  input  logic                             bad,
  output logic [tbas_pkg::OFFSET_BITS-1:0] offset
);

  localparam int PROD_BITS = tbas_pkg::COORD_BITS + tbas_pkg::PITCH_BITS;

  logic [tbas_pkg::LOG2_BITS-1:0]   xb;
  logic [tbas_pkg::LOG2_BITS-1:0]   yb;
  logic [tbas_pkg::LOG2_BITS-1:0]   common;
  logic [tbas_pkg::OFFSET_BITS-1:0] morton;
  logic [PROD_BITS-1:0]             linear;

  assign xb = (cfg.log2_width > tbas_pkg::LOG2_BITS'(tbas_pkg::MAX_LOG2_SIZE)) ?
              tbas_pkg::LOG2_BITS'(tbas_pkg::MAX_LOG2_SIZE) : cfg.log2_width;
  assign yb = (cfg.log2_height > tbas_pkg::LOG2_BITS'(tbas_pkg::MAX_LOG2_SIZE)) ?
              tbas_pkg::LOG2_BITS'(tbas_pkg::MAX_LOG2_SIZE) : cfg.log2_height;
  assign common = (xb < yb) ? xb : yb;

  // Interleave the common low bits, y even and x odd; stack the leftover bits above.
  always_comb begin
    morton = '0;
    for (int b = 0; b < tbas_pkg::COORD_BITS; b++) begin
      if (tbas_pkg::LOG2_BITS'(b) < common) begin
        morton[2*b]   = uy[b];
        morton[2*b+1] = ux[b];
      end else begin
        if (tbas_pkg::LOG2_BITS'(b) < xb) begin
          morton = morton | (tbas_pkg::OFFSET_BITS'(ux[b]) << (common + b));
        end
        if (tbas_pkg::LOG2_BITS'(b) < yb) begin
          morton = morton | (tbas_pkg::OFFSET_BITS'(uy[b]) << (common + b));
        end
      end
    end
  end

  assign linear = PROD_BITS'(uy) * PROD_BITS'(cfg.row_pitch_words) + PROD_BITS'(ux);

  always_comb begin
    if (bad) begin
      offset = '0;
    end else if (cfg.twiddled) begin
      offset = morton;
    end else begin
      offset = linear[tbas_pkg::OFFSET_BITS-1:0];
    end
  end

endmodule

/* rtl/twiddled_blit_address_swizzle_unit.sv */
// Top level of the twiddled blit address swizzle unit.
//
// Usage: drive req and pulse start; a request is taken at each clock edge
// with start high and busy low. busy is high only during reset, so one
// request can be issued every cycle. Each request yields exactly one result:
// the source word offset (Morton twiddled or linear row times pitch plus
// column), the fetched pixel with optional red/blue byte exchange, and a
// coordinate error flag that forces the offset to zero.
// The request is held in an input register, the offset logic (one 12x14
// multiply or the bit interleave) runs between that and the result register,
// and done pulses for one cycle with result valid.
// Throughput is one request per cycle; there is no result back-pressure, so
// the receiver must take result in the cycle that done is high.
// Configuration is written via cfg_write/cfg_index/cfg_data; the user must
// do so only while no request is in flight (not enforced). Reset clears the
// valids, sets row pitch to one and zeroes the other configuration registers.
module twiddled_blit_address_swizzle_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  tbas_pkg::request_t                req,
  output logic                              done,
  output tbas_pkg::result_t                 result,
  input  logic                              cfg_write,
  input  logic [tbas_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [tbas_pkg::CFG_DATA_BITS-1:0] cfg_data
);

  tbas_pkg::cfg_t                   cfg;
  tbas_pkg::request_t               req_q;
  logic                             req_valid;
  logic [tbas_pkg::COORD_BITS-1:0]  ux;
  logic [tbas_pkg::COORD_BITS-1:0]  uy;
  logic                             bad_x;
  logic                             bad_y;
  logic                             bad;
  logic [tbas_pkg::OFFSET_BITS-1:0] offset;
  logic [tbas_pkg::PIXEL_BITS-1:0]  pixel_swapped;
  tbas_pkg::result_t                result_next;

  assign busy = rst;

  tbas_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      req_valid <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req_q <= req;
    end
  end

  tbas_src_coord u_coord_x (
    .start  (cfg.src_x),
    .idx    (req_q.dst_col),
    .mirror (cfg.flip_mode[0]),
    .coord  (ux),
    .bad    (bad_x)
  );

  tbas_src_coord u_coord_y (
    .start  (cfg.src_y),
    .idx    (req_q.dst_row),
    .mirror (cfg.flip_mode[1]),
    .coord  (uy),
    .bad    (bad_y)
  );

  assign bad = bad_x | bad_y;

  tbas_offset u_offset (
    .cfg    (cfg),
    .ux     (ux),
    .uy     (uy),
    .bad    (bad),
    .offset (offset)
  );

  // Exchange bytes 0 and 2 when swapping red and blue.
  assign pixel_swapped = cfg.swap_rb ?
                         {req_q.pixel_in[31:24], req_q.pixel_in[7:0],
                          req_q.pixel_in[15:8], req_q.pixel_in[23:16]} :
                         req_q.pixel_in;

  always_comb begin
    result_next.src_word_offset = offset;
    result_next.pixel_out       = pixel_swapped;
    result_next.coord_error     = bad;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid) begin
      result <= result_next;
    end
  end

endmodule

/* tb/tb_twiddled_blit_address_swizzle_unit.sv */
// Testbench for the twiddled blit address swizzle unit: directed and random blits against a predictor.
`timescale 1ns / 100ps

module tb_twiddled_blit_address_swizzle_unit;
  import tbas_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 4;
  localparam int COORD_MAX = (1 << COORD_BITS) - 1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  request_t req = '0;
  logic done;
  result_t result;
  logic cfg_write = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = REG_SRC_X;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  request_t pixel_q[$];   // requests waiting to be issued
  result_t fetch_q[$];    // expected fetch results, oldest first
  cfg_t cfg_model;        // register copy seen by the predictor
  cfg_t plan;             // setting the stimulus is built for
  bit gaps_on = 1'b1;
  int mismatches = 0;
  int cycle_count = 0;

  twiddled_blit_address_swizzle_unit dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .req(req),
    .done(done),
    .result(result),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Source offset and reordered pixel for one destination pixel.
  function automatic result_t swizzled_fetch(request_t r, cfg_t c);
    result_t res;
    int cx;
    int cy;
    int xb;
    int yb;
    int common;
    logic [31:0] ux;
    logic [31:0] uy;
    logic [63:0] off;
    logic [31:0] p;
    bit bad;
    bad = 1'b0;
    cx = c.flip_mode[0] ? int'(c.src_x) - 1 - int'(r.dst_col) : int'(c.src_x) + int'(r.dst_col);
    cy = c.flip_mode[1] ? int'(c.src_y) - 1 - int'(r.dst_row) : int'(c.src_y) + int'(r.dst_row);
    if (cx < 0 || cx > COORD_MAX) bad = 1'b1;
    if (cy < 0 || cy > COORD_MAX) bad = 1'b1;
    ux = bad ? 32'd0 : 32'(cx);
    uy = bad ? 32'd0 : 32'(cy);
    off = '0;
    if (!bad && c.twiddled) begin
      xb = (int'(c.log2_width) > MAX_LOG2_SIZE) ? MAX_LOG2_SIZE : int'(c.log2_width);
      yb = (int'(c.log2_height) > MAX_LOG2_SIZE) ? MAX_LOG2_SIZE : int'(c.log2_height);
      common = (xb < yb) ? xb : yb;
      for (int b = 0; b < common; b++) begin
        off[2*b] = uy[b];
        off[2*b+1] = ux[b];
      end
      for (int b = common; b < xb; b++) off[common+b] = ux[b];
      for (int b = common; b < yb; b++) off[common+b] = uy[b];
    end else if (!bad) begin
      off = 64'(uy) * 64'(c.row_pitch_words) + 64'(ux);
    end
    p = r.pixel_in;
    if (c.swap_rb) p = {p[31:24], p[7:0], p[15:8], p[23:16]};
    res.src_word_offset = off[OFFSET_BITS-1:0];
    res.pixel_out = p;
    res.coord_error = bad;
    return res;
  endfunction

  task automatic report_field(string field, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch on %s: expected %h, got %h", field, want, got);
    end
  endtask

  // Issue the next request; hold start while busy, drop it when idling.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || !busy) begin
      if (pixel_q.size() > 0 && !(gaps_on && $urandom_range(99) < 9)) begin
        req <= pixel_q.pop_front();
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      cfg_model = '0;
      cfg_model.row_pitch_words = 14'd1;
    end else begin
      if (done) begin
        if (fetch_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("result with nothing expected: %h", result);
        end else begin
          want = fetch_q.pop_front();
          report_field("src_word_offset", 32'(result.src_word_offset),
                       32'(want.src_word_offset));
          report_field("pixel_out", result.pixel_out, want.pixel_out);
          report_field("coord_error", 32'(result.coord_error), 32'(want.coord_error));
        end
      end
      if (start && !busy) fetch_q.push_back(swizzled_fetch(req, cfg_model));
      if (cfg_write) begin
        case (cfg_index)
          REG_SRC_X:       cfg_model.src_x = cfg_data[START_BITS-1:0];
          REG_SRC_Y:       cfg_model.src_y = cfg_data[START_BITS-1:0];
          REG_FLIP_MODE:   cfg_model.flip_mode = cfg_data[1:0];
          REG_TWIDDLED:    cfg_model.twiddled = cfg_data[0];
          REG_LOG2_WIDTH:  cfg_model.log2_width = cfg_data[LOG2_BITS-1:0];
          REG_LOG2_HEIGHT: cfg_model.log2_height = cfg_data[LOG2_BITS-1:0];
          REG_ROW_PITCH:   cfg_model.row_pitch_words = cfg_data[PITCH_BITS-1:0];
          REG_SWAP_RB:     cfg_model.swap_rb = cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Fill bits above the register width with noise when junk is set.
  function automatic logic [CFG_DATA_BITS-1:0] pad(logic [CFG_DATA_BITS-1:0] v, int w,
                                                    bit junk);
    logic [CFG_DATA_BITS-1:0] r;
    r = junk ? CFG_DATA_BITS'($urandom) : '0;
    for (int i = 0; i < w; i++) r[i] = v[i];
    return r;
  endfunction

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic program_regs(int sx, int sy, int fl, int tw, int lw, int lh, int pitch,
                              int sw, bit junk);
    plan.src_x = START_BITS'(sx);
    plan.src_y = START_BITS'(sy);
    plan.flip_mode = 2'(fl);
    plan.twiddled = 1'(tw);
    plan.log2_width = LOG2_BITS'(lw);
    plan.log2_height = LOG2_BITS'(lh);
    plan.row_pitch_words = PITCH_BITS'(pitch);
    plan.swap_rb = 1'(sw);
    write_reg(REG_SRC_X, pad(CFG_DATA_BITS'(plan.src_x), START_BITS, junk));
    write_reg(REG_SRC_Y, pad(CFG_DATA_BITS'(plan.src_y), START_BITS, junk));
    write_reg(REG_FLIP_MODE, pad(CFG_DATA_BITS'(plan.flip_mode), 2, junk));
    write_reg(REG_TWIDDLED, pad(CFG_DATA_BITS'(plan.twiddled), 1, junk));
    write_reg(REG_LOG2_WIDTH, pad(CFG_DATA_BITS'(plan.log2_width), LOG2_BITS, junk));
    write_reg(REG_LOG2_HEIGHT, pad(CFG_DATA_BITS'(plan.log2_height), LOG2_BITS, junk));
    write_reg(REG_ROW_PITCH, pad(CFG_DATA_BITS'(plan.row_pitch_words), PITCH_BITS, junk));
    write_reg(REG_SWAP_RB, pad(CFG_DATA_BITS'(plan.swap_rb), 1, junk));
  endtask

  task automatic queue_pixel(int col, int row, logic [31:0] pix);
    request_t r;
    r.dst_col = COORD_BITS'(col);
    r.dst_row = COORD_BITS'(row);
    r.pixel_in = pix;
    pixel_q.push_back(r);
  endtask

  // Wait until every request is issued and answered, then let the pipe settle.
  task automatic drain();
    do @(posedge clk); while (pixel_q.size() != 0 || start || fetch_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Mostly indexes that land inside the surface, the rest anywhere.
  function automatic int box_index(int origin, bit mirror);
    int span;
    span = mirror ? origin - 1 : COORD_MAX - origin;
    if (span > COORD_MAX) span = COORD_MAX;
    if (span < 0 || $urandom_range(99) < 20) return $urandom_range(COORD_MAX);
    return $urandom_range(span);
  endfunction

  function automatic int random_start();
    case ($urandom_range(7))
      0: return 0;
      1: return 1 << COORD_BITS;
      2: return (1 << START_BITS) - 1;
      default: return $urandom_range(1 << COORD_BITS);
    endcase
  endfunction

  function automatic int random_log2();
    return ($urandom_range(9) == 0) ? $urandom_range(15, 13) : $urandom_range(12);
  endfunction

  function automatic int random_pitch();
    case ($urandom_range(19))
      0: return 0;
      1: return $urandom_range((1 << PITCH_BITS) - 1, 8193);
      2: return 8192;
      default: return $urandom_range(8192, 1);
    endcase
  endfunction

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // reset setting: linear, pitch one, no flip, no swap
    queue_pixel(0, 0, 32'h0000_0000);
    queue_pixel(COORD_MAX, COORD_MAX, 32'hFFFF_FFFF);
    queue_pixel(1, 0, 32'h1234_5678);
    drain();

    // both axes mirrored from the far edge, twiddled, swap
    program_regs(4096, 4096, 3, 1, 12, 12, 1, 1, 1'b0);
    queue_pixel(0, 0, 32'hA5A5_5A5A);
    queue_pixel(COORD_MAX, COORD_MAX, 32'h00FF_00FF);
    queue_pixel(COORD_MAX, 0, 32'hFF00_FF00);
    drain();

    // oversized log2, y mirrored: negative row and column past the edge
    program_regs(100, 50, 2, 1, 15, 13, 0, 0, 1'b0);
    queue_pixel(0, 49, 32'hDEAD_BEEF);
    queue_pixel(0, 50, 32'hCAFE_F00D);
    queue_pixel(3996, 0, 32'h0102_0304);
    queue_pixel(3995, 0, 32'h8070_6050);
    drain();

    // coordinate bits above the surface size are dropped
    program_regs(0, 0, 0, 1, 3, 9, 1, 1, 1'b0);
    queue_pixel(COORD_MAX, COORD_MAX, 32'h1111_2222);
    queue_pixel(12'hABC, 12'h123, 32'h3333_4444);
    drain();
    program_regs(0, 0, 0, 1, 11, 0, 1, 0, 1'b0);
    queue_pixel(1023, 5, 32'h5555_6666);
    queue_pixel(COORD_MAX, COORD_MAX, 32'h7777_8888);
    drain();

    // linear pitch of zero, oversized pitch, largest legal pitch
    program_regs(0, 0, 0, 0, 0, 0, 0, 0, 1'b0);
    queue_pixel(7, COORD_MAX, 32'h9999_AAAA);
    drain();
    program_regs(0, 0, 0, 0, 0, 0, (1 << PITCH_BITS) - 1, 0, 1'b0);
    queue_pixel(COORD_MAX, COORD_MAX, 32'hBBBB_CCCC);
    drain();
    program_regs(0, 0, 0, 0, 0, 0, 8192, 1, 1'b0);
    queue_pixel(COORD_MAX, COORD_MAX, 32'hDDDD_EEEE);
    drain();

    for (int phase = 0; phase < 23; phase++) begin
      program_regs(random_start(), random_start(), $urandom_range(3), $urandom_range(1),
                   random_log2(), random_log2(), random_pitch(), $urandom_range(1),
                   $urandom_range(3) == 0);
      gaps_on = !(phase >= 8 && phase <= 10);
      for (int i = 0; i < 50; i++)
        queue_pixel(box_index(int'(plan.src_x), plan.flip_mode[0]),
                    box_index(int'(plan.src_y), plan.flip_mode[1]), $urandom);
      drain();
    end

    if (mismatches == 0 && fetch_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/tbas_pkg.sv
rtl/tbas_cfg_regs.sv
rtl/tbas_src_coord.sv
rtl/tbas_offset.sv
rtl/twiddled_blit_address_swizzle_unit.sv
tb/tb_twiddled_blit_address_swizzle_unit.sv
